// File: hw/rtl/rhse_pkg.sv
// ----------------------------------------------------------------------------
// Rolling hash substring engine package
// Shared constants, codes, request types and modular add/subtract helpers.
// ----------------------------------------------------------------------------
package rhse_pkg;

    localparam int MAX_LEN = 4096;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int LW      = AW + 1;
    localparam int HW      = 61;

    localparam logic [HW-1:0] MOD61     = {HW{1'b1}};
    localparam logic [HW-1:0] BASE_INIT = HW'(131);

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_CONCAT = 3'd3;
    localparam logic [2:0] CMD_LCP    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic          start;
        logic [HW-1:0] a;
        logic [HW-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic          pre_we;
        logic          pow_we;
        logic [AW-1:0] wr_addr;
        logic [HW-1:0] pre_wdata;
        logic [HW-1:0] pow_wdata;
        logic [AW-1:0] pre_raddr;
        logic [AW-1:0] pow_raddr;
    } st_req_t;

    function automatic logic [HW-1:0] addmod(input logic [HW-1:0] x, input logic [HW-1:0] y);
        logic [HW:0] t;
        t = {1'b0, x} + {1'b0, y};
        if (t >= {1'b0, MOD61})
        begin
            t = t - {1'b0, MOD61};
        end
        return t[HW-1:0];
    endfunction

    function automatic logic [HW-1:0] submod(input logic [HW-1:0] x, input logic [HW-1:0] y);
        logic [HW:0] t;
        t = {1'b0, x} + {1'b0, MOD61} - {1'b0, y};
        if (t >= {1'b0, MOD61})
        begin
            t = t - {1'b0, MOD61};
        end
        return t[HW-1:0];
    endfunction

endpackage

// File: hw/rtl/rhse_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Product mod 2^61-1 from four 31x31 partial products on one multiplier,
// then a fold; result and done pulse are registered.
// ----------------------------------------------------------------------------
module rhse_mulmod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rhse_pkg::mm_req_t        req,
    output logic                     done,
    output logic [rhse_pkg::HW-1:0]  result
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [2:0]              step_reg, step_next;
    logic [rhse_pkg::HW-1:0] a_reg, a_next;
    logic [rhse_pkg::HW-1:0] b_reg, b_next;
    logic [63:0]             acc_reg, acc_next;
    logic [rhse_pkg::HW-1:0] res_reg, res_next;
    logic [30:0]             op_x, op_y;
    logic [61:0]             prod;
    logic [63:0]             addend;
    logic [rhse_pkg::HW:0]   fold;

    always_comb
    begin
        op_x = a_reg[30:0];
        op_y = b_reg[30:0];
        unique case (step_reg)
            3'd1:    op_y = {1'b0, b_reg[60:31]};
            3'd2:    op_x = {1'b0, a_reg[60:31]};
            3'd3:
            begin
                op_x = {1'b0, a_reg[60:31]};
                op_y = {1'b0, b_reg[60:31]};
            end
            default: ;
        endcase
        prod = {31'd0, op_x} * {31'd0, op_y};
        unique case (step_reg)
            3'd1, 3'd2: addend = {32'd0, prod[61:30]} + {3'd0, prod[29:0], 31'd0};
            3'd3:       addend = {1'b0, prod, 1'b0};
            default:    addend = {2'd0, prod};
        endcase
        fold = {{(rhse_pkg::HW-2){1'b0}}, acc_reg[63:61]} + {1'b0, acc_reg[60:0]};
        if (fold >= {1'b0, rhse_pkg::MOD61})
        begin
            fold = fold - {1'b0, rhse_pkg::MOD61};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (busy_reg)
        begin
            if (step_reg == 3'd4)
            begin
                res_next  = fold[rhse_pkg::HW-1:0];
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                acc_next  = acc_reg + addend;
                step_next = step_reg + 3'd1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: hw/rtl/rhse_store.sv
// ----------------------------------------------------------------------------
// Prefix hash and power tables
// Two single-port-write memories with one registered read port each.
// ----------------------------------------------------------------------------
module rhse_store (
    input  logic                     clk,
    input  rhse_pkg::st_req_t        req,
    output logic [rhse_pkg::HW-1:0]  pre_q,
    output logic [rhse_pkg::HW-1:0]  pow_q
);

    logic [rhse_pkg::HW-1:0] pre_mem [rhse_pkg::MAX_LEN];
    logic [rhse_pkg::HW-1:0] pow_mem [rhse_pkg::MAX_LEN];
    logic [rhse_pkg::HW-1:0] pre_q_reg;
    logic [rhse_pkg::HW-1:0] pow_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.pre_we)
        begin
            pre_mem[req.wr_addr] <= req.pre_wdata;
        end
        pre_q_reg <= pre_mem[req.pre_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.pow_we)
        begin
            pow_mem[req.wr_addr] <= req.pow_wdata;
        end
        pow_q_reg <= pow_mem[req.pow_raddr];
    end

    assign pre_q = pre_q_reg;
    assign pow_q = pow_q_reg;

endmodule

// File: hw/rtl/rolling_hash_substring_engine.sv
// ----------------------------------------------------------------------------
// Rolling hash substring engine
// Polynomial hash mod 2^61-1 over one stored byte string, one shared
// modular multiplier under a command sequencer.
// One command is handled at a time; throughput is set by the shared
// multiplier and the single read port of each table. Reset empties the
// string, sets the hash base to 131; table contents stay undefined until
// written.
// ----------------------------------------------------------------------------
module rolling_hash_substring_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rhse_pkg::HW-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               command,
    input  logic [7:0]               char_value,
    input  logic [rhse_pkg::LW-1:0]  start_a,
    input  logic [rhse_pkg::LW-1:0]  end_a,
    input  logic [rhse_pkg::LW-1:0]  start_b,
    input  logic [rhse_pkg::LW-1:0]  end_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [rhse_pkg::HW-1:0]  hash_value,
    output logic [rhse_pkg::LW-1:0]  prefix_length,
    output logic [1:0]               status
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_RDL     = 14'b00000000000010,
        S_MUL1    = 14'b00000000000100,
        S_RDR     = 14'b00000000001000,
        S_MWAIT   = 14'b00000000010000,
        S_DISP    = 14'b00000000100000,
        S_CC_RD   = 14'b00000001000000,
        S_CC_M    = 14'b00000010000000,
        S_CC_W    = 14'b00000100000000,
        S_LCP_CHK = 14'b00001000000000,
        S_AP_RD   = 14'b00010000000000,
        S_AP_M1   = 14'b00100000000000,
        S_AP_W1   = 14'b01000000000000,
        S_AP_W2   = 14'b10000000000000
    } state_t;

    localparam int LW = rhse_pkg::LW;
    localparam int HW = rhse_pkg::HW;
    localparam int AW = rhse_pkg::AW;

    state_t            state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              phase_reg, phase_next;
    logic [LW-1:0]     n_reg, n_next;
    logic [HW-1:0]     base_reg, base_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [7:0]        ch_reg, ch_next;
    logic [LW-1:0]     sa_reg, sa_next, sb_reg, sb_next, eb_reg, eb_next;
    logic [LW-1:0]     l_reg, l_next, r_reg, r_next, mid_reg, mid_next;
    logic signed [LW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [HW-1:0]     pr_reg, pr_next, h_reg, h_next, h1_reg, h1_next, h2_reg, h2_next;
    logic [HW-1:0]     res_hv_reg, res_hv_next;
    logic [LW-1:0]     res_pl_reg, res_pl_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              ov_reg, ov_next;
    logic [HW-1:0]     ohv_reg, ohv_next;
    logic [LW-1:0]     opl_reg, opl_next;
    logic [1:0]        ost_reg, ost_next;

    rhse_pkg::mm_req_t mm_req;
    logic              mm_done;
    logic [HW-1:0]     mm_res;
    rhse_pkg::st_req_t st_req;
    logic [HW-1:0]     pre_q, pow_q;

    logic [LW-1:0]     len_lr, len_b, rem_a, rem_b, lcp_len;
    logic signed [LW:0] diff;
    logic signed [LW+1:0] msum;

    rhse_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .done   (mm_done),
        .result (mm_res)
    );

    rhse_store u_store (
        .clk   (clk),
        .req   (st_req),
        .pre_q (pre_q),
        .pow_q (pow_q)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE) || pend_reg;

    always_comb
    begin
        len_lr  = r_reg - l_reg;
        len_b   = eb_reg - sb_reg;
        rem_a   = n_reg - start_a;
        rem_b   = n_reg - start_b;
        lcp_len = (rem_a < rem_b) ? rem_a : rem_b;
        diff    = hi_reg - lo_reg;
        msum    = (LW+2)'(lo_reg) + (LW+2)'(hi_reg);
    end

    always_comb
    begin
        st_req           = '0;
        st_req.wr_addr   = n_reg[AW-1:0];
        st_req.pow_wdata = mm_res;
        st_req.pre_wdata = rhse_pkg::addmod(mm_res, {{(HW-8){1'b0}}, ch_reg});
        mm_req           = '0;
        mm_req.a         = base_reg;

        state_next  = state_reg;
        pend_next   = pend_reg;
        phase_next  = phase_reg;
        n_next      = n_reg;
        base_next   = base_reg;
        cmd_next    = cmd_reg;
        ch_next     = ch_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        eb_next     = eb_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        mid_next    = mid_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pr_next     = pr_reg;
        h_next      = h_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        res_hv_next = res_hv_reg;
        res_pl_next = res_pl_reg;
        res_st_next = res_st_reg;
        ov_next     = ov_reg;
        ohv_next    = ohv_reg;
        opl_next    = opl_reg;
        ost_next    = ost_reg;

        if (cfg_valid)
        begin
            base_next = cfg_data;
        end

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (pend_reg && (!ov_reg || !out_stall))
        begin
            ov_next   = 1'b1;
            ohv_next  = res_hv_reg;
            opl_next  = res_pl_reg;
            ost_next  = res_st_reg;
            pend_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !pend_reg)
                begin
                    cmd_next    = command;
                    ch_next     = char_value;
                    sa_next     = start_a;
                    sb_next     = start_b;
                    eb_next     = end_b;
                    phase_next  = 1'b0;
                    res_hv_next = '0;
                    res_pl_next = '0;
                    res_st_next = rhse_pkg::ST_OK;
                    unique case (command)
                        rhse_pkg::CMD_CLEAR:
                        begin
                            n_next    = '0;
                            pend_next = 1'b1;
                        end
                        rhse_pkg::CMD_APPEND:
                        begin
                            if (n_reg == LW'(rhse_pkg::MAX_LEN))
                            begin
                                res_st_next = rhse_pkg::ST_FULL;
                                pend_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_AP_RD;
                            end
                        end
                        rhse_pkg::CMD_SUB:
                        begin
                            if (start_a <= end_a && end_a <= n_reg)
                            begin
                                l_next     = start_a;
                                r_next     = end_a;
                                state_next = S_RDL;
                            end
                            else
                            begin
                                res_st_next = rhse_pkg::ST_RANGE;
                                pend_next   = 1'b1;
                            end
                        end
                        rhse_pkg::CMD_CONCAT:
                        begin
                            if (start_a <= end_a && end_a <= n_reg &&
                                start_b <= end_b && end_b <= n_reg)
                            begin
                                l_next     = start_a;
                                r_next     = end_a;
                                state_next = S_RDL;
                            end
                            else
                            begin
                                res_st_next = rhse_pkg::ST_RANGE;
                                pend_next   = 1'b1;
                            end
                        end
                        rhse_pkg::CMD_LCP:
                        begin
                            if (start_a <= n_reg && start_b <= n_reg)
                            begin
                                lo_next    = -(LW+1)'(1);
                                hi_next    = (LW+1)'(lcp_len) + (LW+1)'(1);
                                state_next = S_LCP_CHK;
                            end
                            else
                            begin
                                res_st_next = rhse_pkg::ST_RANGE;
                                pend_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RDL:
            begin
                st_req.pre_raddr = AW'(l_reg - LW'(1));
                st_req.pow_raddr = AW'(len_lr - LW'(1));
                state_next       = S_MUL1;
            end
            S_MUL1:
            begin
                mm_req.start     = 1'b1;
                mm_req.a         = (l_reg == '0) ? '0 : pre_q;
                mm_req.b         = (len_lr == '0) ? HW'(1) : pow_q;
                st_req.pre_raddr = AW'(r_reg - LW'(1));
                state_next       = S_RDR;
            end
            S_RDR:
            begin
                pr_next    = (r_reg == '0) ? '0 : pre_q;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mm_done)
                begin
                    h_next     = rhse_pkg::submod(pr_reg, mm_res);
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (cmd_reg == rhse_pkg::CMD_SUB)
                begin
                    res_hv_next = h_reg;
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmd_reg == rhse_pkg::CMD_CONCAT)
                begin
                    if (!phase_reg)
                    begin
                        h1_next    = h_reg;
                        l_next     = sb_reg;
                        r_next     = eb_reg;
                        phase_next = 1'b1;
                        state_next = S_RDL;
                    end
                    else
                    begin
                        h2_next    = h_reg;
                        state_next = S_CC_RD;
                    end
                end
                else
                begin
                    if (!phase_reg)
                    begin
                        h1_next    = h_reg;
                        l_next     = sb_reg;
                        r_next     = sb_reg + mid_reg;
                        phase_next = 1'b1;
                        state_next = S_RDL;
                    end
                    else
                    begin
                        if (h1_reg == h_reg)
                        begin
                            lo_next = (LW+1)'(mid_reg);
                        end
                        else
                        begin
                            hi_next = (LW+1)'(mid_reg);
                        end
                        state_next = S_LCP_CHK;
                    end
                end
            end
            S_CC_RD:
            begin
                st_req.pow_raddr = AW'(len_b - LW'(1));
                state_next       = S_CC_M;
            end
            S_CC_M:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = h1_reg;
                mm_req.b     = (len_b == '0) ? HW'(1) : pow_q;
                state_next   = S_CC_W;
            end
            S_CC_W:
            begin
                if (mm_done)
                begin
                    res_hv_next = rhse_pkg::addmod(mm_res, h2_reg);
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LCP_CHK:
            begin
                if (diff > (LW+1)'(1))
                begin
                    mid_next   = LW'(msum >>> 1);
                    l_next     = sa_reg;
                    r_next     = sa_reg + LW'(msum >>> 1);
                    phase_next = 1'b0;
                    state_next = S_RDL;
                end
                else
                begin
                    res_pl_next = LW'(lo_reg);
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_AP_RD:
            begin
                st_req.pre_raddr = AW'(n_reg - LW'(1));
                st_req.pow_raddr = AW'(n_reg - LW'(1));
                state_next       = S_AP_M1;
            end
            S_AP_M1:
            begin
                mm_req.start = 1'b1;
                mm_req.b     = (n_reg == '0) ? HW'(1) : pow_q;
                pr_next      = (n_reg == '0) ? '0 : pre_q;
                state_next   = S_AP_W1;
            end
            S_AP_W1:
            begin
                if (mm_done)
                begin
                    st_req.pow_we = 1'b1;
                    mm_req.start  = 1'b1;
                    mm_req.b      = pr_reg;
                    state_next    = S_AP_W2;
                end
            end
            S_AP_W2:
            begin
                if (mm_done)
                begin
                    st_req.pre_we = 1'b1;
                    n_next        = n_reg + LW'(1);
                    pend_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            n_reg     <= '0;
            base_reg  <= rhse_pkg::BASE_INIT;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            n_reg     <= n_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        cmd_reg    <= cmd_next;
        ch_reg     <= ch_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        eb_reg     <= eb_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        mid_reg    <= mid_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pr_reg     <= pr_next;
        h_reg      <= h_next;
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        res_hv_reg <= res_hv_next;
        res_pl_reg <= res_pl_next;
        res_st_reg <= res_st_next;
        ohv_reg    <= ohv_next;
        opl_reg    <= opl_next;
        ost_reg    <= ost_next;
    end

    assign out_valid     = ov_reg;
    assign hash_value    = ohv_reg;
    assign prefix_length = opl_reg;
    assign status        = ost_reg;

endmodule
